// ===== sv/dzrv_pkg.sv =====
// Package for the delta / zigzag / run-length / varint encoder.
// Holds the run request type, the back-end phase type and shared constants.
// No dependencies.
package dzrv_pkg;

  // Widths fixed by the stream format
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 7;

  // Largest run count before an early flush
  localparam logic [COUNT_W-1:0] MAX_RUN_COUNT = '1;

  // Default depth of the run request queue
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // One finished run, handed from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] delta;
    logic [COUNT_W-1:0] count;
    logic               item_last;
    logic               block_last;
  } run_req_t;

  // Serializer phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DELTA,
    PH_COUNT
  } phase_t;

endpackage

// ===== sv/dzrv_front.sv =====
// Front end: takes in column values, forms zigzag deltas and keeps the open run.
// Issues finished runs as requests to the queue. Uses dzrv_pkg.
module dzrv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [dzrv_pkg::VALUE_W-1:0]  in_sample_value,
  input  logic                          in_end_of_block,
  output logic                          q_push,
  output dzrv_pkg::run_req_t            q_data,
  input  logic                          q_full
);

  logic [dzrv_pkg::VALUE_W-1:0] prev_r, prev_nxt;
  logic [dzrv_pkg::VALUE_W-1:0] run_delta_r, run_delta_nxt;
  logic [dzrv_pkg::COUNT_W-1:0] run_len_r, run_len_nxt;
  logic                         pend_r, pend_nxt;
  dzrv_pkg::run_req_t           pend_req_r, pend_req_nxt;

  logic [dzrv_pkg::VALUE_W-1:0] diff;
  logic [dzrv_pkg::VALUE_W-1:0] delta;
  logic                         is_new;
  logic                         is_sat;
  logic                         first_need;
  logic [dzrv_pkg::VALUE_W-1:0] new_delta;
  logic [dzrv_pkg::COUNT_W-1:0] new_len;
  dzrv_pkg::run_req_t           first_req;
  dzrv_pkg::run_req_t           second_req;
  logic                         accept;

  // Wrapping difference, then zigzag map
  assign diff  = in_sample_value - prev_r;
  assign delta = {diff[dzrv_pkg::VALUE_W-2:0], 1'b0} ^ {dzrv_pkg::VALUE_W{diff[dzrv_pkg::VALUE_W-1]}};

  // Classify against the open run
  assign is_new     = (run_len_r == '0) || (delta != run_delta_r);
  assign is_sat     = (run_len_r == dzrv_pkg::MAX_RUN_COUNT);
  assign first_need = (run_len_r != '0) && (is_new || is_sat);
  assign new_delta  = is_new ? delta : run_delta_r;
  assign new_len    = (is_new || is_sat) ? dzrv_pkg::COUNT_W'(1)
                                         : run_len_r + dzrv_pkg::COUNT_W'(1);

  // Old run being closed, and the run flushed at end of block
  always_comb begin
    first_req.delta       = run_delta_r;
    first_req.count       = run_len_r;
    first_req.item_last   = !in_end_of_block;
    first_req.block_last  = 1'b0;
    second_req.delta      = new_delta;
    second_req.count      = new_len;
    second_req.item_last  = 1'b1;
    second_req.block_last = 1'b1;
  end

  // Hold off new values while a flush request still waits or the queue is full
  assign full   = pend_r || q_full;
  assign accept = push && !full;

  // Issue at most one request a cycle; park the second one
  always_comb begin
    prev_nxt      = prev_r;
    run_delta_nxt = run_delta_r;
    run_len_nxt   = run_len_r;
    pend_nxt      = pend_r;
    pend_req_nxt  = pend_req_r;
    q_push        = 1'b0;
    q_data        = first_req;
    if (pend_r) begin
      q_data = pend_req_r;
      if (!q_full) begin
        q_push   = 1'b1;
        pend_nxt = 1'b0;
      end
    end else if (accept) begin
      run_delta_nxt = new_delta;
      run_len_nxt   = in_end_of_block ? '0 : new_len;
      prev_nxt      = in_end_of_block ? '0 : in_sample_value;
      if (first_need) begin
        q_push = 1'b1;
        q_data = first_req;
        if (in_end_of_block) begin
          pend_nxt     = 1'b1;
          pend_req_nxt = second_req;
        end
      end else if (in_end_of_block) begin
        q_push = 1'b1;
        q_data = second_req;
      end
    end
  end

  // Run state and parked request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      run_delta_r <= '0;
      run_len_r   <= '0;
      pend_r      <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      run_delta_r <= run_delta_nxt;
      run_len_r   <= run_len_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_req_r <= pend_req_nxt;
  end

endmodule

// ===== sv/dzrv_fifo.sv =====
// Short queue of run requests between front and back ends.
// Register storage, head read in place. Uses dzrv_pkg.
module dzrv_fifo #(
  parameter int unsigned DEPTH = dzrv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  dzrv_pkg::run_req_t wr_data,
  output logic               q_full,
  input  logic               rd_en,
  output dzrv_pkg::run_req_t rd_data,
  output logic               q_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dzrv_pkg::run_req_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == FULL_CNT);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/dzrv_back.sv =====
// Back end: serializes each run request as a varint of the delta, then of the count.
// One output byte a cycle while pop is held and a run is in flight, from a shift register. Uses dzrv_pkg.
module dzrv_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dzrv_pkg::run_req_t            q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [dzrv_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_item_last,
  output logic                          out_block_last
);

  dzrv_pkg::phase_t             state_r, state_nxt;
  logic [dzrv_pkg::VALUE_W-1:0] sh_r, sh_nxt;
  logic [dzrv_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                         il_r, il_nxt;
  logic                         bl_r, bl_nxt;
  logic                         more;
  logic                         take;

  // More groups follow while bits above the low seven remain
  assign more  = |sh_r[dzrv_pkg::VALUE_W-1:dzrv_pkg::GROUP_W];
  assign empty = (state_r == dzrv_pkg::PH_IDLE);
  assign take  = pop && !empty;

  assign out_byte       = {more, sh_r[dzrv_pkg::GROUP_W-1:0]};
  assign out_item_last  = (state_r == dzrv_pkg::PH_COUNT) && !more && il_r;
  assign out_block_last = (state_r == dzrv_pkg::PH_COUNT) && !more && bl_r;

  // Phase sequencing and shift
  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    il_nxt    = il_r;
    bl_nxt    = bl_r;
    q_pop     = 1'b0;
    unique case (state_r)
      dzrv_pkg::PH_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          sh_nxt    = q_data.delta;
          cnt_nxt   = q_data.count;
          il_nxt    = q_data.item_last;
          bl_nxt    = q_data.block_last;
          state_nxt = dzrv_pkg::PH_DELTA;
        end
      end
      dzrv_pkg::PH_DELTA: begin
        if (take) begin
          if (more) begin
            sh_nxt = sh_r >> dzrv_pkg::GROUP_W;
          end else begin
            sh_nxt    = {{(dzrv_pkg::VALUE_W-dzrv_pkg::COUNT_W){1'b0}}, cnt_r};
            state_nxt = dzrv_pkg::PH_COUNT;
          end
        end
      end
      dzrv_pkg::PH_COUNT: begin
        if (take) begin
          if (more) begin
            sh_nxt = sh_r >> dzrv_pkg::GROUP_W;
          end else if (!q_empty) begin
            q_pop     = 1'b1;
            sh_nxt    = q_data.delta;
            cnt_nxt   = q_data.count;
            il_nxt    = q_data.item_last;
            bl_nxt    = q_data.block_last;
            state_nxt = dzrv_pkg::PH_DELTA;
          end else begin
            state_nxt = dzrv_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dzrv_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dzrv_pkg::PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload of the request in flight
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    il_r  <= il_nxt;
    bl_r  <= bl_nxt;
  end

endmodule

// ===== sv/delta_zigzag_rle_varint_encoder.sv =====
// Top level of the delta / zigzag / run-length / varint encoder.
// Joins dzrv_front, dzrv_fifo and dzrv_back. Uses dzrv_pkg.
//
//   channel  handshake     fields
//   input    push / full   in_sample_value[63:0], in_end_of_block
//   output   empty / pop   out_byte[7:0], out_item_last, out_block_last
//
// A value that only extends its run issues no run request. A value that
// closes a run and ends the block issues two run requests, one a cycle while
// the queue has room, so full rises in the cycle after it until the second is queued.
// The serializer sends one byte a cycle while pop is held and a run is in flight, 2 to 15 bytes per run;
// the run queue depth sets how far input runs ahead. Reset is synchronous and
// clears run state, queue and serializer at once. full also rises while the run queue is full.
module delta_zigzag_rle_varint_encoder #(
  parameter int unsigned QUEUE_DEPTH = dzrv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [dzrv_pkg::VALUE_W-1:0]  in_sample_value,
  input  logic                          in_end_of_block,
  output logic                          empty,
  input  logic                          pop,
  output logic [dzrv_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_item_last,
  output logic                          out_block_last
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  dzrv_pkg::run_req_t q_wr_data;
  dzrv_pkg::run_req_t q_rd_data;

  // Classify values and keep the open run
  dzrv_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_sample_value (in_sample_value),
    .in_end_of_block (in_end_of_block),
    .q_push          (q_push),
    .q_data          (q_wr_data),
    .q_full          (q_full)
  );

  // Buffer run requests
  dzrv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  // Serialize runs into varint bytes
  dzrv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_rd_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_item_last  (out_item_last),
    .out_block_last (out_block_last)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("run request pushed into a full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("run request popped from an empty queue");

  // End of block is always the end of an item
  a_block_is_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_block_last) |-> out_item_last)
    else $error("block_last without item_last");

  // The last byte of an item closes a varint
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item_last) |-> !out_byte[dzrv_pkg::BYTE_W-1])
    else $error("item_last on a continuation byte");

endmodule
